// ===== design/windowed_frame_rate_meter_defines.svh =====
// Assertion macros shared by the frame rate meter modules.
// Depends on nothing; each macro expects signals named clk and arst_n in scope.
`ifndef WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WFRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WFRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wfrm_pkg.sv =====
// Shared types and constants of the windowed frame rate meter.
// Depends on nothing; used by every module of the block.
package wfrm_pkg;

	localparam int DUR_W     = 24;
	localparam int TIME_W    = 40;
	localparam int RATE_W    = 20;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 4;
	localparam int NUM_WINDOWS = 3;

	// Frames per second with four fraction bits: 16 * 1e6 microseconds.
	localparam logic [DUR_W-1:0]  RATE_SCALE = 24'd16000000;
	localparam logic [RATE_W-1:0] RATE_MAX   = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID_WINDOW       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW      = 4'd3;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_REFRESH_INTERVAL = 24'd250000;
	localparam logic [CFG_W-1:0] RST_SHORT_WINDOW     = 24'd1000000;
	localparam logic [CFG_W-1:0] RST_MID_WINDOW       = 24'd5000000;
	localparam logic [CFG_W-1:0] RST_LONG_WINDOW      = 24'd10000000;

	// Window slots.
	localparam logic [1:0] WIN_SHORT = 2'd0;
	localparam logic [1:0] WIN_MID   = 2'd1;
	localparam logic [1:0] WIN_LONG  = 2'd2;

	// One history entry as stored in the ring memory.
	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [DUR_W-1:0]  duration;
	} ring_entry_t;

endpackage

// ===== design/windowed_frame_rate_meter.sv =====
// Top level of the windowed frame rate meter: control sequencer, ring walk and result register.
// Depends on wfrm_pkg, wfrm_ring_ram, wfrm_rate_div and windowed_frame_rate_meter_defines.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------------
//  in      | in_valid / in_stall        | frame_duration_us, frame_time_us, instant_rate
//  out     | out_valid / out_stall      | refreshed, shown_rate, shown_duration_us,
//          |                            | avg_short, avg_mid, avg_long, peak_rate
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A frame that does not refresh goes from the idle state straight to the finish state.
// A refreshing frame walks the ring once for all three windows, one RAM read per cycle,
// then runs the shared divider three times, one window after another.
// Reset clears all control and latched values; the ring RAM is not cleared.
// The finished result sits in the output register while the next frame is taken;
// a frame finishing while that register is still stalled waits for it to drain.
`include "windowed_frame_rate_meter_defines.svh"

module windowed_frame_rate_meter #(
	parameter int HISTORY_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Frame input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [wfrm_pkg::DUR_W-1:0]           frame_duration_us,
	input  logic [wfrm_pkg::TIME_W-1:0]          frame_time_us,
	input  logic [wfrm_pkg::RATE_W-1:0]          instant_rate,
	// Result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 refreshed,
	output logic [wfrm_pkg::RATE_W-1:0]          shown_rate,
	output logic [wfrm_pkg::DUR_W-1:0]           shown_duration_us,
	output logic [wfrm_pkg::RATE_W-1:0]          avg_short,
	output logic [wfrm_pkg::RATE_W-1:0]          avg_mid,
	output logic [wfrm_pkg::RATE_W-1:0]          avg_long,
	output logic [wfrm_pkg::RATE_W-1:0]          peak_rate,
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wfrm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wfrm_pkg::CFG_W-1:0]           cfg_data
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = wfrm_pkg::DUR_W + CW;
	localparam int NW    = wfrm_pkg::NUM_WINDOWS;
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);
	localparam logic [1:0]    WIN_LAST  = 2'(NW - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [wfrm_pkg::CFG_W-1:0] refresh_interval_q;
	logic [wfrm_pkg::CFG_W-1:0] window_len_q [NW];

	// Persistent meter state.
	logic [AW-1:0]                  write_slot_q;
	logic [CW-1:0]                  filled_q;
	logic [wfrm_pkg::RATE_W-1:0]    peak_q;
	logic [wfrm_pkg::TIME_W-1:0]    last_refresh_q;
	logic [wfrm_pkg::RATE_W-1:0]    latched_rate_q;
	logic [wfrm_pkg::DUR_W-1:0]     latched_dur_q;
	logic [wfrm_pkg::RATE_W-1:0]    avg_q [NW];
	logic                           refresh_q;

	// Walk and divide working registers.
	logic [AW-1:0]                  rd_addr_q;
	logic [CW-1:0]                  issued_q;
	logic                           rd_pend_s1;
	logic [NW-1:0]                  active_q;
	logic [wfrm_pkg::TIME_W-1:0]    cutoff_q [NW];
	logic [SUM_W-1:0]               sum_q [NW];
	logic [CW-1:0]                  cnt_q [NW];
	logic [1:0]                     win_q;

	// Output register.
	logic                           out_valid_q;
	logic                           out_refreshed_q;
	logic [wfrm_pkg::RATE_W-1:0]    out_rate_q;
	logic [wfrm_pkg::DUR_W-1:0]     out_dur_q;
	logic [wfrm_pkg::RATE_W-1:0]    out_avg_q [NW];
	logic [wfrm_pkg::RATE_W-1:0]    out_peak_q;

	// Combinational helpers.
	logic                           in_take;
	logic                           out_free;
	logic                           do_refresh;
	logic [wfrm_pkg::TIME_W:0]      refresh_due;
	logic [wfrm_pkg::TIME_W:0]      cut_diff [NW];
	logic [wfrm_pkg::TIME_W-1:0]    cut_new [NW];
	logic                           issue;
	logic                           ram_wr_en;
	wfrm_pkg::ring_entry_t          ram_wr_data;
	wfrm_pkg::ring_entry_t          ram_rd_data;
	logic                           div_start;
	logic                           div_done;
	logic [wfrm_pkg::RATE_W-1:0]    div_quotient;

	// Handshakes: config is always taken; frames only when the sequencer is idle.
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Refresh decision and window cutoffs (clamped at zero) for the incoming frame.
	assign refresh_due = {1'b0, last_refresh_q} + (wfrm_pkg::TIME_W + 1)'(refresh_interval_q);
	assign do_refresh  = ({1'b0, frame_time_us} >= refresh_due);

	always_comb begin
		for (int w = 0; w < NW; w++) begin
			cut_diff[w] = {1'b0, frame_time_us} - (wfrm_pkg::TIME_W + 1)'(window_len_q[w]);
			cut_new[w]  = cut_diff[w][wfrm_pkg::TIME_W] ? '0
			                                            : cut_diff[w][wfrm_pkg::TIME_W-1:0];
		end
	end

	// Ring access: write at frame acceptance, one read per walk cycle.
	assign ram_wr_en            = in_take;
	assign ram_wr_data.stamp    = frame_time_us;
	assign ram_wr_data.duration = frame_duration_us;
	assign issue = (state_q == ST_WALK) && (issued_q < filled_q) && (|active_q);

	wfrm_ring_ram #(
		.DEPTH  (HISTORY_DEPTH),
		.ADDR_W (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (write_slot_q),
		.wr_data (ram_wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr_q),
		.rd_data (ram_rd_data)
	);

	// Shared divider, one window at a time.
	assign div_start = (state_q == ST_DIV_START);

	wfrm_rate_div #(
		.CNT_W (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.count    (cnt_q[win_q]),
		.sum      (sum_q[win_q]),
		.quotient (div_quotient),
		.done     (div_done)
	);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_interval_q           <= wfrm_pkg::RST_REFRESH_INTERVAL;
			window_len_q[wfrm_pkg::WIN_SHORT] <= wfrm_pkg::RST_SHORT_WINDOW;
			window_len_q[wfrm_pkg::WIN_MID]   <= wfrm_pkg::RST_MID_WINDOW;
			window_len_q[wfrm_pkg::WIN_LONG]  <= wfrm_pkg::RST_LONG_WINDOW;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wfrm_pkg::REG_REFRESH_INTERVAL: refresh_interval_q <= cfg_data;
				wfrm_pkg::REG_SHORT_WINDOW:     window_len_q[wfrm_pkg::WIN_SHORT] <= cfg_data;
				wfrm_pkg::REG_MID_WINDOW:       window_len_q[wfrm_pkg::WIN_MID]   <= cfg_data;
				wfrm_pkg::REG_LONG_WINDOW:      window_len_q[wfrm_pkg::WIN_LONG]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, meter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			write_slot_q    <= '0;
			filled_q        <= '0;
			peak_q          <= '0;
			last_refresh_q  <= '0;
			latched_rate_q  <= '0;
			latched_dur_q   <= '0;
			refresh_q       <= 1'b0;
			issued_q        <= '0;
			rd_pend_s1      <= 1'b0;
			active_q        <= '0;
			win_q           <= '0;
			out_valid_q     <= 1'b0;
			out_refreshed_q <= 1'b0;
			out_rate_q      <= '0;
			out_dur_q       <= '0;
			out_peak_q      <= '0;
			for (int w = 0; w < NW; w++) begin
				avg_q[w]     <= '0;
				out_avg_q[w] <= '0;
			end
		end else begin
			// The downstream side took the pending transaction.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_s1 <= issue;

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
						if (filled_q != FULL_CNT) begin
							filled_q <= filled_q + 1'b1;
						end
						if (instant_rate > peak_q) begin
							peak_q <= instant_rate;
						end
						refresh_q <= do_refresh;
						issued_q  <= '0;
						active_q  <= '1;
						win_q     <= wfrm_pkg::WIN_SHORT;
						if (do_refresh) begin
							latched_rate_q <= instant_rate;
							latched_dur_q  <= frame_duration_us;
							last_refresh_q <= frame_time_us;
							state_q        <= ST_WALK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					if (issue) begin
						issued_q <= issued_q + 1'b1;
					end
					// A window stops at its first entry older than its cutoff.
					if (rd_pend_s1) begin
						for (int w = 0; w < NW; w++) begin
							if (active_q[w] && (ram_rd_data.stamp < cutoff_q[w])) begin
								active_q[w] <= 1'b0;
							end
						end
					end
					if (!issue && !rd_pend_s1) begin
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						avg_q[win_q] <= div_quotient;
						if (win_q == WIN_LAST) begin
							state_q <= ST_FINISH;
						end else begin
							win_q   <= win_q + 1'b1;
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						out_refreshed_q <= refresh_q;
						out_rate_q      <= latched_rate_q;
						out_dur_q       <= latched_dur_q;
						out_peak_q      <= peak_q;
						for (int w = 0; w < NW; w++) begin
							out_avg_q[w] <= avg_q[w];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath: read address, cutoffs and per-window sums and counts.
	always_ff @(posedge clk) begin
		if (in_take) begin
			rd_addr_q <= write_slot_q;
			for (int w = 0; w < NW; w++) begin
				cutoff_q[w] <= cut_new[w];
				sum_q[w]    <= '0;
				cnt_q[w]    <= '0;
			end
		end else begin
			if (issue) begin
				rd_addr_q <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - 1'b1;
			end
			if (rd_pend_s1) begin
				for (int w = 0; w < NW; w++) begin
					if (active_q[w] && !(ram_rd_data.stamp < cutoff_q[w])) begin
						sum_q[w] <= sum_q[w] + SUM_W'(ram_rd_data.duration);
						cnt_q[w] <= cnt_q[w] + 1'b1;
					end
				end
			end
		end
	end

	// Output ports.
	assign out_valid         = out_valid_q;
	assign refreshed         = out_refreshed_q;
	assign shown_rate        = out_rate_q;
	assign shown_duration_us = out_dur_q;
	assign avg_short         = out_avg_q[wfrm_pkg::WIN_SHORT];
	assign avg_mid           = out_avg_q[wfrm_pkg::WIN_MID];
	assign avg_long          = out_avg_q[wfrm_pkg::WIN_LONG];
	assign peak_rate         = out_peak_q;

	`WFRM_ASSERT_NOW(a_no_rw_overlap, ram_wr_en, !issue, "ring write and walk read in one cycle")
	`WFRM_ASSERT_NOW(a_walk_bound, state_q == ST_WALK, issued_q <= filled_q, "walk ran past filled entries")
	`WFRM_ASSERT_NOW(a_fill_bound, 1'b1, filled_q <= FULL_CNT, "fill count beyond history depth")
	`WFRM_ASSERT_NOW(a_div_done_state, div_done, state_q == ST_DIV_WAIT, "divider finished outside wait state")

endmodule

// ===== design/wfrm_ring_ram.sv =====
// History ring storage: simple dual-port synchronous RAM with a registered read port.
// Depends on wfrm_pkg for the entry type.
module wfrm_ring_ram #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  wfrm_pkg::ring_entry_t    wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output wfrm_pkg::ring_entry_t    rd_data
);

	wfrm_pkg::ring_entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/wfrm_rate_div.sv =====
// Average rate unit: count * 16e6 / sum by restoring division, one bit per cycle.
// Depends on wfrm_pkg and the assertion macros in windowed_frame_rate_meter_defines.svh.
`include "windowed_frame_rate_meter_defines.svh"

module wfrm_rate_div #(
	parameter int CNT_W = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [CNT_W-1:0]                    count,
	input  logic [wfrm_pkg::DUR_W+CNT_W-1:0]    sum,
	output logic [wfrm_pkg::RATE_W-1:0]         quotient,
	output logic                                done
);

	localparam int W      = wfrm_pkg::DUR_W + CNT_W;
	localparam int STEP_W = $clog2(W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      num_q;
	logic [W-1:0]      den_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic              zero_q;

	logic [W:0]        rem_shift;
	logic [W+1:0]      trial;
	logic              fits;

	// One restoring step: shift in the next numerator bit and try the subtract.
	assign rem_shift = {rem_q, num_q[W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, den_q};
	assign fits      = !trial[W+1];

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the numerator product is formed once when the division starts.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= W'(count) * W'(wfrm_pkg::RATE_SCALE);
			den_q  <= sum;
			zero_q <= (sum == '0);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[W-1:0] : rem_shift[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
			num_q <= {num_q[W-2:0], 1'b0};
		end
	end

	// A zero sum gives zero; a quotient past 20 bits saturates.
	always_comb begin
		if (zero_q) begin
			quotient = '0;
		end else if (|quo_q[W-1:wfrm_pkg::RATE_W]) begin
			quotient = wfrm_pkg::RATE_MAX;
		end else begin
			quotient = quo_q[wfrm_pkg::RATE_W-1:0];
		end
	end

	assign done = done_q;

	`WFRM_ASSERT_NOW(a_start_when_idle, start, !busy_q, "division started while busy")
	`WFRM_ASSERT_NEXT(a_done_single, done_q, !done_q && !busy_q, "done held longer than one cycle")
	`WFRM_ASSERT_NOW(a_zero_sum_result, done_q && zero_q, quotient == '0, "zero sum gave nonzero rate")

endmodule
